// ----- hw/rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps
// Types, character codes and queue sizes shared by the JSON string unescaper.
// No dependencies; every module of the block imports this package.
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic       bad_escape;
  } out_item_t;

  // One classified input item: up to three bytes, plus the end marks.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n_bytes;
    logic            end_mark;
    logic            bad;
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  localparam int Q_DEPTH  = 4;
  localparam int Q_ADDR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_F         = 8'h66;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

endpackage

// ----- hw/rtl/json_string_unescaper.sv -----
`timescale 1ns / 1ps
// JSON string unescaper, top level: front end, command queue and back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Feed the escaped body of a JSON string one byte per item, marking the final
// byte with last_byte; results come out as unescaped bytes, UTF-8 for \u
// escapes, with end_of_text on the last one (an empty end item if the final
// byte produced nothing) and bad_escape when the string stopped inside \u.
// Input is taken at one byte a cycle while the command queue is not full; output
// runs at one byte a cycle while out_stall is low, so a three-byte UTF-8 sequence
// takes three output items while the four-entry command queue keeps accepting
// input. A result passes the queue entry, written at the accepting edge, and
// then the output register, loaded once the back end reaches it and is not stalled.
module json_string_unescaper import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic q_push, q_pop, q_empty, q_full;
  cmd_t q_cmd, q_head;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/jsu_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts raw bytes, tracks the escape state and turns each item
// into a queue command of zero to three bytes. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;

  logic       accept;
  logic [7:0] c;
  logic [4:0] digit;
  cmd_t       cmd;

  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
    else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
    else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign c        = in_item.in_byte;
  assign digit    = hex_digit(c);

  always_comb begin
    mode_next        = mode;
    hex_count_next   = hex_count;
    hex_value_next   = hex_value;
    hex_stopped_next = hex_stopped;
    cmd              = '0;
    unique case (mode)
      MODE_ESCAPE: begin
        mode_next   = MODE_NORMAL;
        cmd.n_bytes = 2'd1;
        case (c)
          CHAR_B:  cmd.bytes[0] = CTRL_BS;
          CHAR_F:  cmd.bytes[0] = CTRL_FF;
          CHAR_N:  cmd.bytes[0] = CTRL_LF;
          CHAR_R:  cmd.bytes[0] = CTRL_CR;
          CHAR_T:  cmd.bytes[0] = CTRL_HT;
          CHAR_U: begin
            mode_next        = MODE_HEX;
            cmd.n_bytes      = 2'd0;
            hex_count_next   = 2'd0;
            hex_value_next   = 16'd0;
            hex_stopped_next = 1'b0;
          end
          default: cmd.bytes[0] = c;
        endcase
      end
      MODE_HEX: begin
        if (!hex_stopped && digit[4]) hex_value_next = {hex_value[11:0], digit[3:0]};
        else hex_stopped_next = 1'b1;
        if (hex_count == 2'd3) begin
          // encode the finished code point as UTF-8
          if (hex_value_next < 16'h0080) begin
            cmd.n_bytes  = 2'd1;
            cmd.bytes[0] = hex_value_next[7:0];
          end else if (hex_value_next < 16'h0800) begin
            cmd.n_bytes  = 2'd2;
            cmd.bytes[0] = {3'b110, hex_value_next[10:6]};
            cmd.bytes[1] = {2'b10, hex_value_next[5:0]};
          end else begin
            cmd.n_bytes  = 2'd3;
            cmd.bytes[0] = {4'b1110, hex_value_next[15:12]};
            cmd.bytes[1] = {2'b10, hex_value_next[11:6]};
            cmd.bytes[2] = {2'b10, hex_value_next[5:0]};
          end
          mode_next        = MODE_NORMAL;
          hex_count_next   = 2'd0;
          hex_value_next   = 16'd0;
          hex_stopped_next = 1'b0;
        end else begin
          hex_count_next = hex_count + 2'd1;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (c == CHAR_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          cmd.n_bytes  = 2'd1;
          cmd.bytes[0] = c;
        end
      end
    endcase
    if (in_item.last_byte) begin
      cmd.end_mark     = 1'b1;
      cmd.bad          = (mode_next == MODE_HEX);
      mode_next        = MODE_NORMAL;
      hex_count_next   = 2'd0;
      hex_value_next   = 16'd0;
      hex_stopped_next = 1'b0;
    end
  end

  assign q_push = accept && ((cmd.n_bytes != 2'd0) || in_item.last_byte);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      hex_count   <= 2'd0;
      hex_value   <= 16'd0;
      hex_stopped <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      hex_count   <= hex_count_next;
      hex_value   <= hex_value_next;
      hex_stopped <= hex_stopped_next;
    end
  end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on jsu_pkg for the command type and depth.
module jsu_queue import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t                entries [Q_DEPTH];
  logic [Q_ADDR_W-1:0] wr_ptr;
  logic [Q_ADDR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0]  count;

  assign empty = (count == Q_CNT_W'(0));
  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_ADDR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_ADDR_W'(1);
      if (push && !pop) count <= count + Q_CNT_W'(1);
      else if (pop && !push) count <= count - Q_CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue popped while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + Q_CNT_W'(1)))
    else $error("queue count lost a push");
`endif

endmodule

// ----- hw/rtl/jsu_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the bytes of the queue head, one result item a cycle when not
// stalled, into a registered output stage. Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       load;
  logic       final_item;
  out_item_t  item;

  assign last_idx   = (head.n_bytes == 2'd0) ? 2'd0 : head.n_bytes - 2'd1;
  assign final_item = (idx == last_idx);
  assign load       = (!out_valid || !out_stall) && !empty;
  assign pop        = load && final_item;

  always_comb begin
    item.byte_valid  = (head.n_bytes != 2'd0);
    item.out_byte    = item.byte_valid ? head.bytes[idx] : 8'h00;
    item.end_of_text = head.end_mark && final_item;
    item.bad_escape  = head.bad && final_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_item ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item <= item;
  end

`ifndef SYNTHESIS
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.byte_valid) |-> out_item.end_of_text)
    else $error("empty result without end mark");
  a_bad_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.bad_escape) |-> out_item.end_of_text)
    else $error("bad escape flag off the end item");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> (!empty && idx <= last_idx))
    else $error("byte index beyond queue head");
`endif

endmodule
